### rtl/pu_pkg.sv
// Package: widths, codes and types shared by the partition unranker.
`timescale 1ns / 1ps
`default_nettype none

package pu_pkg;

    localparam int RANK_W        = 48;
    localparam int PART_W        = 8;
    localparam int PC_W          = 4;
    localparam int TOT_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;
    localparam int MAX_PARTS_DEF = 10;
    localparam int MAX_TOTAL_DEF = 255;

    localparam logic [RANK_W-1:0] CNT_MAX = {RANK_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = 2'd1;

    typedef enum logic [0:0] {
        ALU_ADD_SAT,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [RANK_W-1:0] a;
        logic [RANK_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [RANK_W-1:0] result;
        logic              le;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        ST_BLD_ENTRY,
        ST_BLD_RDB,
        ST_BLD_WR,
        ST_IDLE,
        ST_CHK,
        ST_RD,
        ST_CMP,
        ST_ERR
    } state_t;

endpackage

`default_nettype wire

### rtl/pu_if.sv
// Interfaces: rank query channel and part result channel.
`timescale 1ns / 1ps
`default_nettype none

interface pu_query_if import pu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output rank, input ready);
    modport sink   (input valid, input rank, output ready);
endinterface

interface pu_part_if import pu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PART_W-1:0] part_value;
    logic              last_part;
    logic              rank_error;

    modport source (output valid, output part_value, output last_part, output rank_error,
                    input ready);
    modport sink   (input valid, input part_value, input last_part, input rank_error,
                    output ready);
endinterface

`default_nettype wire

### rtl/partition_unranker_core.sv
// Partition unranker top level: sequencer, configuration and output register.
// After reset the block fills its count table, with query.ready low: an entry on row or
// column zero is written directly, one entry per cycle; any other entry takes a read of
// entry (l-1, s-1), a read of entry (l, s-l) when s >= l, and a write of their saturated
// sum. A rank then gets a range check against the table entry for the configuration, then
// for every candidate part value scanned one table read and one pass through the shared
// 48-bit subtractor. Each part is loaded into the output register when its candidate is
// taken and the register is free; a part waits while it is full and parts.ready is low.
// One rank is worked at a time; ready rises again when its last beat is loaded into the
// output register. An invalid configuration or an out-of-range rank gives a single beat
// with rank_error and last_part set.
`timescale 1ns / 1ps
`default_nettype none

module partition_unranker_core import pu_pkg::*; #(
    parameter int MAX_PARTS = MAX_PARTS_DEF,
    parameter int MAX_TOTAL = MAX_TOTAL_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    pu_query_if.sink                   query,
    pu_part_if.source                  parts
);

    localparam int RW = $clog2(MAX_PARTS + 1);
    localparam int TW = $clog2(MAX_TOTAL + 1);

    state_t            state_reg, state_next;
    logic [RW-1:0]     bl_reg, bl_next;
    logic [TW-1:0]     bs_reg, bs_next;
    logic [RANK_W-1:0] a_reg, a_next;
    logic [RANK_W-1:0] rank_left_reg, rank_left_next;
    logic [PC_W-1:0]   l_reg, l_next;
    logic [TW-1:0]     d_reg, d_next;
    logic [TW-1:0]     i_reg, i_next;
    logic [PC_W-1:0]   part_count_reg;
    logic [TOT_W-1:0]  total_reg;

    logic              out_valid_reg, out_valid_next;
    logic [PART_W-1:0] out_part_reg, out_part_next;
    logic              out_last_reg, out_last_next;
    logic              out_err_reg, out_err_next;

    logic              rd_en, wr_en;
    logic [RW-1:0]     rd_row, wr_row;
    logic [TW-1:0]     rd_col, wr_col;
    logic [RANK_W-1:0] wr_data, rd_data;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    logic emit_ok, cfg_bad, bld_last, bld_s_ge_l, at_top, pick;

    pu_table #(
        .MAX_PARTS (MAX_PARTS),
        .MAX_TOTAL (MAX_TOTAL)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_col  (rd_col),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_col  (wr_col),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    pu_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_count_reg <= PC_W'(1);
            total_reg      <= TOT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PART_COUNT: part_count_reg <= cfg_data[PC_W-1:0];
                REG_TOTAL:      total_reg      <= cfg_data[TOT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BLD_ENTRY;
            bl_reg        <= '0;
            bs_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bl_reg        <= bl_next;
            bs_reg        <= bs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        rank_left_reg <= rank_left_next;
        l_reg         <= l_next;
        d_reg         <= d_next;
        i_reg         <= i_next;
        out_part_reg  <= out_part_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    assign emit_ok    = !out_valid_reg || parts.ready;
    assign cfg_bad    = (part_count_reg == '0) || (32'(part_count_reg) > MAX_PARTS)
                        || (32'(total_reg) > MAX_TOTAL)
                        || (total_reg < TOT_W'(part_count_reg));
    assign bld_last   = (bl_reg == RW'(MAX_PARTS)) && (bs_reg == TW'(MAX_TOTAL));
    assign bld_s_ge_l = 32'(bs_reg) >= 32'(bl_reg);
    assign at_top     = 32'(d_reg) < 32'(l_reg);
    assign pick       = at_top || alu_rsp.le;

    always_comb
    begin
        state_next     = state_reg;
        bl_next        = bl_reg;
        bs_next        = bs_reg;
        a_next         = a_reg;
        rank_left_next = rank_left_reg;
        l_next         = l_reg;
        d_next         = d_reg;
        i_next         = i_reg;
        out_part_next  = out_part_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !parts.ready;
        rd_en          = 1'b0;
        rd_row         = '0;
        rd_col         = '0;
        wr_en          = 1'b0;
        wr_row         = bl_reg;
        wr_col         = bs_reg;
        wr_data        = alu_rsp.result;
        alu_req.op     = ALU_SUB;
        alu_req.a      = rank_left_reg;
        alu_req.b      = rd_data;
        query.ready    = 1'b0;

        unique case (state_reg)
            ST_BLD_ENTRY:
            begin
                if (bl_reg == '0 || bs_reg == '0)
                begin
                    wr_en   = 1'b1;
                    wr_data = (bl_reg == '0 && bs_reg == '0) ? RANK_W'(1) : '0;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_row     = bl_reg - RW'(1);
                    rd_col     = bs_reg - TW'(1);
                    state_next = ST_BLD_RDB;
                end
            end
            ST_BLD_RDB:
            begin
                a_next     = rd_data;
                rd_en      = bld_s_ge_l;
                rd_row     = bl_reg;
                rd_col     = TW'(32'(bs_reg) - 32'(bl_reg));
                state_next = ST_BLD_WR;
            end
            ST_BLD_WR:
            begin
                alu_req.op = ALU_ADD_SAT;
                alu_req.a  = a_reg;
                alu_req.b  = bld_s_ge_l ? rd_data : '0;
                wr_en      = 1'b1;
                state_next = ST_BLD_ENTRY;
            end
            ST_IDLE:
            begin
                query.ready = 1'b1;
                if (query.valid)
                begin
                    rank_left_next = query.rank;
                    if (cfg_bad)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_row     = RW'(part_count_reg);
                        rd_col     = TW'(total_reg);
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                if (rank_left_reg == '0 || !alu_rsp.le)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    l_next     = part_count_reg;
                    d_next     = TW'(total_reg) - TW'(part_count_reg);
                    i_next     = TW'(1);
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                rd_row     = RW'(l_reg - PC_W'(1));
                rd_col     = TW'(32'(d_reg) + 32'(l_reg) - 1);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (pick)
                begin
                    if (emit_ok)
                    begin
                        out_valid_next = 1'b1;
                        out_part_next  = PART_W'(i_reg);
                        out_last_next  = (l_reg == PC_W'(1));
                        out_err_next   = 1'b0;
                        l_next         = l_reg - PC_W'(1);
                        state_next     = (l_reg == PC_W'(1)) ? ST_IDLE : ST_RD;
                    end
                end
                else
                begin
                    rank_left_next = alu_rsp.result;
                    i_next         = i_reg + TW'(1);
                    d_next         = TW'(32'(d_reg) - 32'(l_reg));
                    state_next     = ST_RD;
                end
            end
            ST_ERR:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_part_next  = '0;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en)
        begin
            if (bld_last)
            begin
                state_next = ST_IDLE;
            end
            else if (bs_reg == TW'(MAX_TOTAL))
            begin
                bs_next = '0;
                bl_next = bl_reg + RW'(1);
            end
            else
            begin
                bs_next = bs_reg + TW'(1);
            end
        end
    end

    assign parts.valid      = out_valid_reg;
    assign parts.part_value = out_part_reg;
    assign parts.last_part  = out_last_reg;
    assign parts.rank_error = out_err_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (query.valid && query.ready) |=> !query.ready)
        else $error("query accepted while a rank is in progress");

    a_no_beat_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLD_ENTRY || state_reg == ST_BLD_RDB || state_reg == ST_BLD_WR)
        |-> (!out_valid_reg && !query.ready))
        else $error("activity during table build");

    a_descent_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (rank_left_reg != '0 && l_reg != '0 && i_reg != '0))
        else $error("descent registers out of range");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (parts.valid && parts.rank_error) |-> (parts.last_part && parts.part_value == '0))
        else $error("error beat not final or not zero");

endmodule

`default_nettype wire

### rtl/pu_table.sv
// Count table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pu_table import pu_pkg::*; #(
    parameter int MAX_PARTS = MAX_PARTS_DEF,
    parameter int MAX_TOTAL = MAX_TOTAL_DEF,
    localparam int RW = $clog2(MAX_PARTS + 1),
    localparam int TW = $clog2(MAX_TOTAL + 1)
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [RW-1:0]     rd_row,
    input  wire logic [TW-1:0]     rd_col,
    input  wire logic              wr_en,
    input  wire logic [RW-1:0]     wr_row,
    input  wire logic [TW-1:0]     wr_col,
    input  wire logic [RANK_W-1:0] wr_data,
    output logic      [RANK_W-1:0] rd_data
);

    logic [RANK_W-1:0] mem [0:MAX_PARTS][0:MAX_TOTAL];
    logic [RANK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row][wr_col] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row][rd_col];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/pu_alu.sv
// Shared 48-bit unit: saturating add for the table build, subtract/compare for the range check and the descent.
`timescale 1ns / 1ps
`default_nettype none

module pu_alu import pu_pkg::*; (
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic [RANK_W:0] sum_w;
    logic [RANK_W:0] diff_w;

    always_comb
    begin
        sum_w  = {1'b0, req.a} + {1'b0, req.b};
        diff_w = {1'b0, req.a} - {1'b0, req.b};
        unique case (req.op)
            ALU_ADD_SAT:
            begin
                rsp.result = sum_w[RANK_W] ? CNT_MAX : sum_w[RANK_W-1:0];
                rsp.le     = 1'b0;
            end
            ALU_SUB:
            begin
                rsp.result = diff_w[RANK_W-1:0];
                rsp.le     = diff_w[RANK_W] || (diff_w[RANK_W-1:0] == '0);
            end
            default:
            begin
                rsp.result = diff_w[RANK_W-1:0];
                rsp.le     = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Testbench for partition_unranker_core: rank beats in, part beats checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
    import pu_pkg::*;

    localparam int QUIET_LIMIT  = 25000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 600;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 18;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [PART_W-1:0] part_value;
        logic              last_part;
        logic              rank_error;
    } part_beat_t;

    class unrank_scoreboard;
        logic [RANK_W-1:0] part_counts [0:MAX_PARTS_DEF][0:MAX_TOTAL_DEF];
        logic [PC_W-1:0]   part_count;
        logic [TOT_W-1:0]  total;
        part_beat_t        expected_parts [$];
        int                fails;

        function new();
            logic [RANK_W:0] sum;
            part_count = 1;
            total      = 1;
            fails      = 0;
            for (int l = 0; l <= MAX_PARTS_DEF; l++)
            begin
                for (int s = 0; s <= MAX_TOTAL_DEF; s++)
                begin
                    if (l == 0)
                        sum = (s == 0) ? 1 : 0;
                    else if (s == 0)
                        sum = 0;
                    else
                    begin
                        sum = count_of(l - 1, s - 1);
                        if (s >= l)
                            sum = sum + count_of(l, s - l);
                        if (sum > CNT_MAX)
                            sum = CNT_MAX;
                    end
                    part_counts[l][s] = sum[RANK_W-1:0];
                end
            end
        endfunction

        function logic [RANK_W-1:0] count_of(int l, int s);
            if (l < 0 || l > MAX_PARTS_DEF || s < 0 || s > MAX_TOTAL_DEF)
                return '0;
            return part_counts[l][s];
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_PART_COUNT)
                part_count = data[PC_W-1:0];
            else if (idx == REG_TOTAL)
                total = data[TOT_W-1:0];
        endfunction

        // zero when the configuration itself is invalid
        function logic [RANK_W-1:0] rank_count();
            if (part_count < 1 || int'(part_count) > MAX_PARTS_DEF ||
                int'(total) > MAX_TOTAL_DEF || total < part_count)
                return '0;
            return count_of(part_count, total);
        endfunction

        function int pending();
            return expected_parts.size();
        endfunction

        function void note_rank(logic [RANK_W-1:0] rank);
            logic [RANK_W-1:0] left;
            logic [RANK_W-1:0] c;
            logic [RANK_W-1:0] n;
            int                rem, lo, pl, top, cand, pick;
            bit                found;
            part_beat_t        beat;
            n = rank_count();
            if (n == 0 || rank == 0 || rank > n)
            begin
                beat.part_value = '0;
                beat.last_part  = 1'b1;
                beat.rank_error = 1'b1;
                expected_parts.push_back(beat);
                return;
            end
            left = rank;
            rem  = total;
            lo   = 1;
            pl   = part_count;
            while (pl > 0)
            begin
                top   = rem / pl;
                pick  = top;
                cand  = lo;
                found = 1'b0;
                // first candidate whose count covers the rank left is taken, else the top one
                while (!found && cand <= top)
                begin
                    c = count_of(pl - 1, rem - cand - (pl - 1) * (cand - 1));
                    if (cand == top || left <= c)
                    begin
                        pick  = cand;
                        found = 1'b1;
                    end
                    else
                    begin
                        left = left - c;
                        cand++;
                    end
                end
                rem = rem - pick;
                lo  = pick;
                pl--;
                beat.part_value = pick[PART_W-1:0];
                beat.last_part  = (pl == 0);
                beat.rank_error = 1'b0;
                expected_parts.push_back(beat);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            fails++;
        endtask

        task check_part(part_beat_t got);
            part_beat_t want;
            if (expected_parts.size() == 0)
            begin
                report($sformatf("unexpected beat part_value=%0d last_part=%0b rank_error=%0b",
                                 got.part_value, got.last_part, got.rank_error));
                return;
            end
            want = expected_parts.pop_front();
            if (got.part_value !== want.part_value)
                report($sformatf("part_value got %0d want %0d", got.part_value,
                                 want.part_value));
            if (got.last_part !== want.last_part)
                report($sformatf("last_part got %0b want %0b", got.last_part, want.last_part));
            if (got.rank_error !== want.rank_error)
                report($sformatf("rank_error got %0b want %0b", got.rank_error,
                                 want.rank_error));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pu_query_if query_bus ();
    pu_part_if  part_bus ();

    unrank_scoreboard sb;
    int send_idle_pct = 19;
    int recv_idle_pct = 60;
    bit hold_req      = 1'b0;

    partition_unranker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .query     (query_bus),
        .parts     (part_bus)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && part_bus.valid && part_bus.ready)
            sb.check_part(part_beat_t'({part_bus.part_value, part_bus.last_part,
                                        part_bus.rank_error}));
        if (rst_n && query_bus.valid && query_bus.ready)
            sb.note_rank(query_bus.rank);
    end

    // receiver: random back-pressure plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        part_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                part_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                part_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((query_bus.valid && query_bus.ready) || (part_bus.valid && part_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_rank(input logic [RANK_W-1:0] rank);
        while ($urandom_range(99) < send_idle_pct)
        begin
            query_bus.valid <= 1'b0;
            @(posedge clk);
        end
        query_bus.valid <= 1'b1;
        query_bus.rank  <= rank;
        @(posedge clk);
        while (!query_bus.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        query_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.apply_reg(idx, data);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] pc_data,
                              input logic [CFG_DATA_W-1:0] tot_data);
        wait_drained();
        repeat (2) @(posedge clk);
        write_reg(REG_PART_COUNT, pc_data);
        write_reg(REG_TOTAL, tot_data);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [RANK_W-1:0] pick_rank();
        logic [RANK_W-1:0] n;
        logic [63:0]       wide;
        int                roll;
        n    = sb.rank_count();
        wide = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (n != 0 && roll < 72)
            return RANK_W'(64'd1 + wide % 64'(n));
        if (roll < 78)
            return ($urandom_range(1)) ? n : 1;
        if (roll < 82)
            return n + 1;
        if (roll < 85)
            return '0;
        return wide[RANK_W-1:0];
    endfunction

    task automatic run_phase(input int idx);
        int        pc_val, tot_val, roll;
        logic [3:0] pad;
        roll   = $urandom_range(99);
        pc_val = (roll < 85) ? $urandom_range(10, 1) : $urandom_range(15, 0);
        roll   = $urandom_range(99);
        if (roll < 60)
        begin
            tot_val = pc_val + $urandom_range(30);
            if (tot_val > 255)
                tot_val = 255;
        end
        else if (roll < 85)
            tot_val = $urandom_range(255, 1);
        else
            tot_val = $urandom_range(255, 0);
        pad = $urandom_range(15);
        set_config({pad, pc_val[3:0]}, tot_val[7:0]);
        if (idx < 4)
        begin
            send_idle_pct = 19;
            recv_idle_pct = 60;
        end
        else if (idx < 8)
        begin
            send_idle_pct = 60;
            recv_idle_pct = 19;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (idx == 2)
            hold_req = 1'b1;
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            if (idx == 6 && k == PHASE_ITEMS / 2)
                wait_drained();
            send_rank(pick_rank());
        end
        query_bus.valid <= 1'b0;
    endtask

    initial
    begin
        logic [RANK_W-1:0] n;
        sb = new();
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_PART_COUNT;
        cfg_data        <= '0;
        query_bus.valid <= 1'b0;
        query_bus.rank  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: one part summing to one
        send_rank(1);
        send_rank(0);
        send_rank(2);
        wait_drained();
        write_reg(REG_SPARE, 8'hFF);
        cfg_we <= 1'b0;
        send_rank(1);

        set_config(8'd10, 8'd255);
        n = sb.rank_count();
        send_rank(1);
        send_rank(n);
        send_rank(n + 1);
        send_rank(CNT_MAX);

        set_config(8'hF4, 8'd20);
        n = sb.rank_count();
        send_rank(0);
        send_rank(1);
        send_rank(n);
        send_rank(48'h5555_5555_5555);
        send_rank(48'hAAAA_AAAA_AAAA);

        // invalid configs: zero parts, too many parts, total below parts
        set_config(8'h00, 8'd8);
        send_rank(1);
        set_config(8'h0F, 8'd200);
        send_rank(1);
        set_config(8'h06, 8'd5);
        send_rank(1);

        set_config(8'h01, 8'hFF);
        send_rank(1);
        set_config(8'h0A, 8'h0A);
        send_rank(1);

        for (int p = 0; p < RAND_PHASES; p++)
            run_phase(p);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d part beats never arrived", sb.pending()));
        if (sb.fails == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
